@@ hdl/email_address_checker_unit_assert.svh @@
// Assertion macros for the email address checker.
// Each macro is empty when SYNTHESIS is defined.
`ifndef EMAIL_ADDRESS_CHECKER_UNIT_ASSERT_SVH
`define EMAIL_ADDRESS_CHECKER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define EAC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked outside reset.
`define EAC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define EAC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define EAC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ hdl/eac_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eac_pkg
// Shared types, character codes, reason codes and the verdict function of
// the email address checker.
// ----------------------------------------------------------------------------
package eac_pkg;

  // Character codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  // Reason codes; lowest failing check wins
  localparam logic [2:0] REASON_OK         = 3'd0;
  localparam logic [2:0] REASON_BLANK      = 3'd1;
  localparam logic [2:0] REASON_INNER_WS   = 3'd2;
  localparam logic [2:0] REASON_AT_COUNT   = 3'd3;
  localparam logic [2:0] REASON_EMPTY_PART = 3'd4;
  localparam logic [2:0] REASON_EDGE_DOT   = 3'd5;
  localparam logic [2:0] REASON_NO_DOT     = 3'd6;

  // '@' counter saturates here
  localparam logic [1:0] AT_ONE = 2'd1;
  localparam logic [1:0] AT_SAT = 2'd2;

  // One input transaction held in the input stage
  typedef struct packed {
    logic [7:0] byte_value;
    logic       last;
  } eac_item_t;

  // Verdict of one address
  typedef struct packed {
    logic       valid_res;
    logic [2:0] reason;
  } eac_result_t;

  // Pipeline handshake between the input stage and the rest
  typedef struct packed {
    logic fire;   // stage item consumed this cycle
    logic load;   // consumed item is final, verdict goes to output
  } eac_ctrl_t;

  // Per-address scan flags
  typedef struct packed {
    logic       seen_content;
    logic       pending_space;
    logic       inner_space;
    logic [1:0] at_count;
    logic       at_was_first;
    logic       domain_started;
    logic       domain_first_dot;
    logic       domain_last_dot;
    logic       domain_has_dot;
  } eac_scan_t;

  // Space, tab, CR, LF: trimmed at both ends
  function automatic logic is_trim_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  // Priority-ordered checks over the flags
  function automatic logic [2:0] verdict(input eac_scan_t s);
    logic [2:0] r;
    if (!s.seen_content) begin
      r = REASON_BLANK;
    end else if (s.inner_space) begin
      r = REASON_INNER_WS;
    end else if (s.at_count != AT_ONE) begin
      r = REASON_AT_COUNT;
    end else if (s.at_was_first || !s.domain_started) begin
      r = REASON_EMPTY_PART;
    end else if (s.domain_first_dot || s.domain_last_dot) begin
      r = REASON_EDGE_DOT;
    end else if (!s.domain_has_dot) begin
      r = REASON_NO_DOT;
    end else begin
      r = REASON_OK;
    end
    return r;
  endfunction

endpackage

@@ hdl/eac_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eac_in_if / eac_out_if
// Valid/ready channels of the checker: address bytes in, verdicts out.
// ----------------------------------------------------------------------------
interface eac_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last;

  modport source (output valid, output byte_value, output last, input ready);
  modport sink   (input valid, input byte_value, input last, output ready);
endinterface

interface eac_out_if;
  logic       valid;
  logic       ready;
  logic       valid_res;
  logic [2:0] reason;

  modport source (output valid, output valid_res, output reason, input ready);
  modport sink   (input valid, input valid_res, input reason, output ready);
endinterface

@@ hdl/eac_in_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eac_in_stage
// Input register. Holds one byte transaction and releases it when the
// output stage can take a verdict, or at once for a non-final byte.
// ----------------------------------------------------------------------------
module eac_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  eac_in_if.sink            in_ch,
  input  logic              out_free,
  output eac_pkg::eac_item_t item,
  output eac_pkg::eac_ctrl_t ctrl
);

  logic               stg_valid_r;
  logic               stg_valid_nxt;
  eac_pkg::eac_item_t stg_item_r;
  logic               fire;
  logic               take;

  // Advance: non-final bytes never wait; final bytes need the result slot
  assign fire = stg_valid_r && (!stg_item_r.last || out_free);
  assign in_ch.ready = !stg_valid_r || fire;
  assign take = in_ch.valid && in_ch.ready;

  always_comb begin
    stg_valid_nxt = stg_valid_r;
    if (take) begin
      stg_valid_nxt = 1'b1;
    end else if (fire) begin
      stg_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (take) begin
      stg_item_r.byte_value <= in_ch.byte_value;
      stg_item_r.last       <= in_ch.last;
    end
  end

  assign item      = stg_item_r;
  assign ctrl.fire = fire;
  assign ctrl.load = fire && stg_item_r.last;

endmodule

@@ hdl/eac_scan.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eac_scan
// Per-address flag registers. Updates the flags from one byte and forms
// the verdict from the updated flags; flags clear after a final byte.
// ----------------------------------------------------------------------------
module eac_scan (
  input  logic                clk,
  input  logic                rst_n,
  input  eac_pkg::eac_item_t  item,
  input  eac_pkg::eac_ctrl_t  ctrl,
  output eac_pkg::eac_result_t res
);

  eac_pkg::eac_scan_t scan_r;
  eac_pkg::eac_scan_t scan_nxt;
  logic               dot;
  logic [2:0]         code;

  // Flag update for one byte
  always_comb begin
    scan_nxt = scan_r;
    dot      = (item.byte_value == eac_pkg::CH_DOT);
    if (eac_pkg::is_trim_blank(item.byte_value)) begin
      if (scan_r.seen_content) begin
        scan_nxt.pending_space = 1'b1;
      end
    end else begin
      if (scan_r.pending_space) begin
        scan_nxt.inner_space = 1'b1;
      end
      scan_nxt.pending_space = 1'b0;
      // vertical tab and form feed are never trimmed
      if ((item.byte_value == eac_pkg::CH_VT) || (item.byte_value == eac_pkg::CH_FF)) begin
        scan_nxt.inner_space = 1'b1;
      end
      if (item.byte_value == eac_pkg::CH_AT) begin
        if (!scan_r.seen_content) begin
          scan_nxt.at_was_first = 1'b1;
        end
        if (scan_r.at_count != eac_pkg::AT_SAT) begin
          scan_nxt.at_count = scan_r.at_count + 2'd1;
        end
      end else if (scan_r.at_count == eac_pkg::AT_ONE) begin
        if (!scan_r.domain_started) begin
          scan_nxt.domain_first_dot = dot;
        end
        scan_nxt.domain_started  = 1'b1;
        scan_nxt.domain_last_dot = dot;
        if (dot) begin
          scan_nxt.domain_has_dot = 1'b1;
        end
      end
      scan_nxt.seen_content = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= '0;
    end else if (ctrl.fire) begin
      scan_r <= item.last ? '0 : scan_nxt;
    end
  end

  // Verdict from the flags including this byte
  assign code          = eac_pkg::verdict(scan_nxt);
  assign res.reason    = code;
  assign res.valid_res = (code == eac_pkg::REASON_OK);

endmodule

@@ hdl/eac_out_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eac_out_stage
// Result register. Holds one verdict until the sink takes it; reports
// when a new verdict can be written.
// ----------------------------------------------------------------------------
module eac_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  eac_pkg::eac_ctrl_t   ctrl,
  input  eac_pkg::eac_result_t res,
  output logic                 out_free,
  eac_out_if.source            out_ch
);

  logic                 out_valid_r;
  logic                 out_valid_nxt;
  eac_pkg::eac_result_t out_res_r;

  // Free when empty or being drained this cycle
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.valid_res = out_res_r.valid_res;
  assign out_ch.reason    = out_res_r.reason;

endmodule

@@ hdl/email_address_checker_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// email_address_checker_unit
// Streaming syntax checker for email addresses, one byte per transaction.
// ----------------------------------------------------------------------------
// Takes one address byte per cycle, with last set on the final byte, and
// gives one verdict (valid_res, reason) per address; the final byte is held
// in the input register and its verdict is then written into the result
// register. Sustained rate is one byte per cycle; a final byte waits in the
// input register only while the previous verdict is held by the sink.
// Leading and trailing space, tab, CR and LF are ignored. Reason codes:
// 0 ok, 1 blank, 2 inner whitespace, 3 not exactly one '@', 4 empty local or
// domain part, 5 domain starts or ends with '.', 6 domain has no '.'; the
// lowest failing code is reported. All flags clear after each final byte.
// ----------------------------------------------------------------------------
`include "email_address_checker_unit_assert.svh"

module email_address_checker_unit (
  input  logic       clk,
  input  logic       rst_n,
  eac_in_if.sink     in_ch,
  eac_out_if.source  out_ch
);

  eac_pkg::eac_item_t   item;
  eac_pkg::eac_ctrl_t   ctrl;
  eac_pkg::eac_result_t res;
  logic                 out_free;

  // Input register
  eac_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_free (out_free),
    .item     (item),
    .ctrl     (ctrl)
  );

  // Flag update and verdict
  eac_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .item  (item),
    .ctrl  (ctrl),
    .res   (res)
  );

  // Result register
  eac_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .res      (res),
    .out_free (out_free),
    .out_ch   (out_ch)
  );

  // A verdict is only written into a free result register
  `EAC_ASSERT_IMP(a_load_free, clk, rst_n, ctrl.load, out_free, "verdict overwrote held result")
  // A written verdict is presented on the next cycle
  `EAC_ASSERT_NXT(a_load_shows, clk, rst_n, ctrl.load, out_ch.valid, "verdict not presented")
  // Accept flag agrees with the reason code
  `EAC_ASSERT_IMP(a_res_code, clk, rst_n, out_ch.valid,
    (out_ch.valid_res == (out_ch.reason == eac_pkg::REASON_OK)) &&
    (out_ch.reason <= eac_pkg::REASON_NO_DOT), "accept flag and reason disagree")

endmodule
